/* rtl/ring_table_seat_and_fork_arbiter_top_defines.svh */
// ---------------------------------------------------------------------------
// Seat and fork arbiter: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef RING_TABLE_SEAT_AND_FORK_ARBITER_TOP_DEFINES_SVH
`define RING_TABLE_SEAT_AND_FORK_ARBITER_TOP_DEFINES_SVH

// condition holds at every clock edge outside reset
`define RTSF_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define RTSF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/rtsf_pkg.sv */
// ---------------------------------------------------------------------------
// Seat and fork arbiter package
// Event codes, result kinds and the command/result records.
// ---------------------------------------------------------------------------
package rtsf_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_HUNGRY = 2'd1,
        OP_DONE   = 2'd2,
        OP_LEAVE  = 2'd3
    } rtsf_op_t;

    typedef enum logic [2:0] {
        KIND_SEATED = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_GRANT  = 3'd2,
        KIND_ACK    = 3'd3,
        KIND_LEFT   = 3'd4
    } rtsf_kind_t;

    typedef struct packed {
        rtsf_op_t   op;
        logic [2:0] seat;
    } rtsf_cmd_t;

    typedef struct packed {
        rtsf_kind_t kind;
        logic [2:0] seat_index;
        logic       last;
    } rtsf_res_t;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);

endpackage

/* rtl/rtsf_front.sv */
// ---------------------------------------------------------------------------
// Seat and fork arbiter front end
// Takes input items, decodes the event and drops out-of-range seats.
// ---------------------------------------------------------------------------
module rtsf_front #(
    parameter int SEATS = 8
) (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2:0]          s_axis_tdata,   // [2:0] seat
    input  logic [1:0]          s_axis_tuser,   // [1:0] opcode
    output logic                push_valid,
    input  logic                push_ready,
    output rtsf_pkg::rtsf_cmd_t push_cmd
);
    import rtsf_pkg::*;

    logic     in_range;
    logic     keep;
    rtsf_op_t op;

    assign op       = rtsf_op_t'(s_axis_tuser);
    assign in_range = ({29'd0, s_axis_tdata} < 32'(SEATS));
    // arrive ignores the seat field; other events on a missing seat vanish here
    assign keep     = (op == OP_ARRIVE) || in_range;

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid && keep;
    assign push_cmd      = '{op: op, seat: s_axis_tdata};

endmodule

/* rtl/rtsf_queue.sv */
// ---------------------------------------------------------------------------
// Seat and fork arbiter command queue
// Two-entry FIFO between the front end and the engine.
// ---------------------------------------------------------------------------
module rtsf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  rtsf_pkg::rtsf_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop,
    output rtsf_pkg::rtsf_cmd_t pop_cmd
);
    import rtsf_pkg::*;

    rtsf_cmd_t            mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]   wr_ptr_reg;
    logic [CMDQ_PW-1:0]   rd_ptr_reg;
    logic [CMDQ_PW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (CMDQ_PW + 1)'(CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/rtsf_engine.sv */
// ---------------------------------------------------------------------------
// Seat and fork arbiter engine
// Holds the seat table, runs each event and drives the result register.
// ---------------------------------------------------------------------------
`include "ring_table_seat_and_fork_arbiter_top_defines.svh"

module rtsf_engine #(
    parameter int SEATS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  rtsf_pkg::rtsf_cmd_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output rtsf_pkg::rtsf_res_t m_res
);
    import rtsf_pkg::*;

    localparam int SW = $clog2(SEATS);
    localparam int FW = $clog2(SEATS + 1);
    localparam logic [SW-1:0] LAST_SEAT = SW'(SEATS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TEST_FIRST,
        ST_TEST_LAST,
        ST_FLUSH
    } state_t;

    state_t          state_reg;
    logic [SEATS-1:0] taken_reg;
    logic [SEATS-1:0] hungry_reg;
    logic [SEATS-1:0] eating_reg;
    logic [FW-1:0]   free_cnt_reg;
    logic [SW-1:0]   seat_reg;
    logic [SW-1:0]   tgt_reg;
    logic [SW-1:0]   idx_reg;
    logic [SW-1:0]   any_reg;
    logic            any_found_reg;
    rtsf_res_t       pend_reg;
    logic            pend_valid_reg;
    rtsf_res_t       out_reg;
    logic            out_valid_reg;

    logic [SW-1:0]   head_seat;
    logic            can_push;
    logic            adv;
    logic            tgt_hit;
    logic            scan_free;
    logic            scan_good;
    logic            scan_done;
    logic [SW-1:0]   scan_pick;
    logic [SEATS-1:0] eat_rot;
    logic            out_load;

    function automatic logic [SW-1:0] left_of(input logic [SW-1:0] s);
        return (s == '0) ? LAST_SEAT : s - 1'b1;
    endfunction

    function automatic logic [SW-1:0] right_of(input logic [SW-1:0] s);
        return (s == LAST_SEAT) ? '0 : s + 1'b1;
    endfunction

    function automatic rtsf_res_t mk_res(input rtsf_kind_t k, input logic [SW-1:0] s);
        return '{kind: k, seat_index: 3'(s), last: 1'b0};
    endfunction

    assign head_seat = SW'(q_head.seat);
    assign can_push  = !out_valid_reg || m_ready;
    // one result is held back so the final one can be marked last
    assign adv       = !pend_valid_reg || can_push;
    assign tgt_hit   = hungry_reg[tgt_reg] && !eating_reg[left_of(tgt_reg)]
                       && !eating_reg[right_of(tgt_reg)];
    assign scan_free = !taken_reg[idx_reg];
    assign scan_good = scan_free && !taken_reg[left_of(idx_reg)]
                       && !taken_reg[right_of(idx_reg)];
    assign scan_done = scan_good || (idx_reg == LAST_SEAT);
    assign scan_pick = scan_good ? idx_reg : (any_found_reg ? any_reg : idx_reg);
    assign eat_rot   = {eating_reg[SEATS-2:0], eating_reg[SEATS-1]};
    // output register loads when a held result moves out
    assign out_load  = ((state_reg inside {ST_TEST_FIRST, ST_TEST_LAST}) && adv && tgt_hit
                        && pend_valid_reg)
                       || ((state_reg == ST_FLUSH) && pend_valid_reg && can_push);

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            taken_reg      <= '0;
            hungry_reg     <= '0;
            eating_reg     <= '0;
            free_cnt_reg   <= FW'(SEATS);
            any_found_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        case (q_head.op)
                            OP_ARRIVE: begin
                                if (free_cnt_reg == '0) begin
                                    pend_reg       <= mk_res(KIND_FULL, '0);
                                    pend_valid_reg <= 1'b1;
                                    state_reg      <= ST_FLUSH;
                                end else begin
                                    idx_reg       <= '0;
                                    any_found_reg <= 1'b0;
                                    state_reg     <= ST_SCAN;
                                end
                            end
                            OP_HUNGRY: begin
                                if (taken_reg[head_seat]) begin
                                    hungry_reg[head_seat] <= 1'b1;
                                    eating_reg[head_seat] <= 1'b0;
                                    tgt_reg               <= head_seat;
                                    state_reg             <= ST_TEST_LAST;
                                end
                            end
                            OP_DONE: begin
                                if (taken_reg[head_seat]) begin
                                    hungry_reg[head_seat] <= 1'b0;
                                    eating_reg[head_seat] <= 1'b0;
                                    pend_reg              <= mk_res(KIND_ACK, head_seat);
                                    pend_valid_reg        <= 1'b1;
                                    seat_reg              <= head_seat;
                                    tgt_reg               <= left_of(head_seat);
                                    state_reg             <= ST_TEST_FIRST;
                                end
                            end
                            OP_LEAVE: begin
                                if (taken_reg[head_seat]) begin
                                    taken_reg[head_seat]  <= 1'b0;
                                    hungry_reg[head_seat] <= 1'b0;
                                    eating_reg[head_seat] <= 1'b0;
                                    free_cnt_reg          <= free_cnt_reg + 1'b1;
                                    pend_reg              <= mk_res(KIND_LEFT, head_seat);
                                    pend_valid_reg        <= 1'b1;
                                    seat_reg              <= head_seat;
                                    tgt_reg               <= left_of(head_seat);
                                    state_reg <= eating_reg[head_seat] ? ST_TEST_FIRST
                                                                       : ST_FLUSH;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // first free seat is the fallback if no isolated seat turns up
                    if (scan_free && !any_found_reg) begin
                        any_reg       <= idx_reg;
                        any_found_reg <= 1'b1;
                    end
                    if (scan_done) begin
                        taken_reg[scan_pick]  <= 1'b1;
                        hungry_reg[scan_pick] <= 1'b0;
                        eating_reg[scan_pick] <= 1'b0;
                        free_cnt_reg          <= free_cnt_reg - 1'b1;
                        pend_reg              <= mk_res(KIND_SEATED, scan_pick);
                        pend_valid_reg        <= 1'b1;
                        state_reg             <= ST_FLUSH;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_TEST_FIRST, ST_TEST_LAST: begin
                    if (adv) begin
                        if (tgt_hit) begin
                            hungry_reg[tgt_reg] <= 1'b0;
                            eating_reg[tgt_reg] <= 1'b1;
                            if (pend_valid_reg) begin
                                out_reg <= pend_reg;
                            end
                            pend_reg       <= mk_res(KIND_GRANT, tgt_reg);
                            pend_valid_reg <= 1'b1;
                        end
                        if (state_reg == ST_TEST_FIRST) begin
                            tgt_reg   <= right_of(seat_reg);
                            state_reg <= ST_TEST_LAST;
                        end else begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (can_push) begin
                        out_reg        <= '{kind: pend_reg.kind,
                                            seat_index: pend_reg.seat_index,
                                            last: 1'b1};
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `RTSF_ASSERT_ALWAYS(a_hungry_eating_excl, aclk, aresetn,
        (hungry_reg & eating_reg) == '0, "seat both hungry and eating")
    `RTSF_ASSERT_ALWAYS(a_no_adjacent_eaters, aclk, aresetn,
        (eating_reg & eat_rot) == '0, "two neighbouring seats eating")
    `RTSF_ASSERT_ALWAYS(a_free_count, aclk, aresetn,
        free_cnt_reg == FW'(SEATS - $countones(taken_reg)), "free seat count out of step")
    `RTSF_ASSERT_IMPL(a_idle_no_pending, aclk, aresetn,
        state_reg == ST_IDLE, !pend_valid_reg, "result left pending at idle")

endmodule

/* rtl/ring_table_seat_and_fork_arbiter_top.sv */
// Events: the engine takes an event from the queue only in its idle state and runs
//   one event at a time; the seat scan for an arrive tests one seat per cycle, and a
//   result waiting on m_axis_tready holds the engine back.
// Reset: aresetn is synchronous, active low; all seats free and thinking, queue empty.
// ---------------------------------------------------------------------------
// Seat and fork arbiter top level
// Ring of SEATS agents sharing a fork with each neighbour. A front end
// accepts and decodes events, a two-entry queue decouples it from the
// engine, which holds the seat table and emits up to three results.
// ---------------------------------------------------------------------------
module ring_table_seat_and_fork_arbiter_top #(
    parameter int SEATS = 8     // ring size, 2 to 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [2:0] seat, [7:3] zero
    input  logic [1:0] s_axis_tuser,    // [1:0] opcode
    // result items
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [2:0] seat_index, [7:3] zero
    output logic [2:0] m_axis_tuser,    // [2:0] kind
    output logic       m_axis_tlast     // final result of an item
);
    import rtsf_pkg::*;

    logic      push_valid;
    logic      push_ready;
    rtsf_cmd_t push_cmd;
    logic      q_valid;
    logic      q_pop;
    rtsf_cmd_t q_head;
    rtsf_res_t m_res;

    // decode, seat range check
    rtsf_front #(
        .SEATS(SEATS)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata[2:0]),
        .s_axis_tuser (s_axis_tuser),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_cmd     (push_cmd)
    );

    // lets the front keep taking items while the engine works
    rtsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_cmd   (q_head)
    );

    // seat table, neighbour tests, result register
    rtsf_engine #(
        .SEATS(SEATS)
    ) u_engine (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_head (q_head),
        .q_pop  (q_pop),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_res  (m_res)
    );

    assign m_axis_tdata = {5'd0, m_res.seat_index};
    assign m_axis_tuser = m_res.kind;
    assign m_axis_tlast = m_res.last;

endmodule
